// ===== design/disk_elevator_scheduler_top_assert.svh =====
// Assertion macros for the disk elevator scheduler.
`ifndef DISK_ELEVATOR_SCHEDULER_TOP_ASSERT_SVH
`define DISK_ELEVATOR_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DES_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("disk elevator scheduler: property violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define DES_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("disk elevator scheduler: property violated");

`endif

// ===== design/des_pkg.sv =====
// Shared types and constants of the disk elevator scheduler.
`default_nettype none

package des_pkg;

  // Most completions delivered for one tick.
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned KW = $clog2(RESULT_LIMIT + 1);

  // Input word modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WEND,
    ST_EMIT
  } state_e;

  // Purpose of the current table walk.
  typedef enum logic {
    OP_ADD,
    OP_SCAN
  } op_e;

  // One result word.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  done_id;
    logic        done_is_read;
    logic [15:0] head_position;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/des_in_if.sv =====
// Input channel of the disk elevator scheduler.
`default_nettype none

interface des_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] track;
  logic [7:0]  requester_id;
  logic        is_read;

  modport source (output valid, mode, track, requester_id, is_read, input ready);
  modport sink   (input valid, mode, track, requester_id, is_read, output ready);
endinterface

`default_nettype wire

// ===== design/des_out_if.sv =====
// Result channel of the disk elevator scheduler.
`default_nettype none

interface des_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  done_id;
  logic        done_is_read;
  logic [15:0] head_position;
  logic        last;

  modport source (output valid, kind, done_id, done_is_read, head_position, last,
                  input ready);
  modport sink   (input valid, kind, done_id, done_is_read, head_position, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/des_cfg_if.sv =====
// Configuration write channel of the disk elevator scheduler.
`default_nettype none

interface des_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_track;

  modport source (output valid, max_track, input ready);
  modport sink   (input valid, max_track, output ready);
endinterface

`default_nettype wire

// ===== design/des_out_stage.sv =====
// Output register stage that holds one result word for the downstream side.
`default_nettype none

module des_out_stage
  import des_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_valid_i,
  output logic         load_ready_o,
  input  wire result_t load_data_i,
  des_out_if.source    out_o
);

  logic    valid_q;
  result_t data_q;

  // The stage takes a new word when empty or when its word leaves now.
  assign load_ready_o = !valid_q || out_o.ready;

  // Valid flag of the held word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_valid_i && load_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Held word payload.
  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      data_q <= load_data_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = data_q.kind;
  assign out_o.done_id       = data_q.done_id;
  assign out_o.done_is_read  = data_q.done_is_read;
  assign out_o.head_position = data_q.head_position;
  assign out_o.last          = data_q.last;

endmodule

`default_nettype wire

// ===== design/disk_elevator_scheduler_top.sv =====
// SCAN elevator disk scheduler: requests live in a registered-read table
// memory of QUEUE_DEPTH entries that a sequencer walks one entry per cycle.
// A dropped add (table full or track above max_track) is answered without a
// walk. An accepted add walks the table once to age the stored requests and
// find a free slot. A tick with pending requests walks the table k + 1 times
// for k completions (at most 16), and a tick that finds nothing at the head's
// track walks it once; a tick on an empty table gives no word. Each walk reads
// through the single memory read port, and the sequencer waits while the
// result channel holds off a word. Results leave through an output register,
// so the next word is accepted while the last result still waits. max_track
// may be written at any time the block is idle; no clearing pass runs after
// reset.
`default_nettype none

module disk_elevator_scheduler_top
  import des_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  des_in_if.sink    item_i,
  des_out_if.source result_o,
  des_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // One table entry; age is the arrival rank, 0 for the newest request.
  typedef struct packed {
    logic [15:0]   track;
    logic [7:0]    owner;
    logic          rd;
    logic [AW-1:0] age;
  } ent_t;

  // Sequencer state.
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   ret_walk_q, ret_walk_d;

  // Walk pipeline: read address counter and the entry whose data returns.
  logic [AW:0]   cnt_q, cnt_d;
  logic          p_vld_q, p_vld_d;
  logic [AW-1:0] p_idx_q, p_idx_d;

  // Scheduler state.
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]          count_q, count_d;
  logic [15:0]            head_q, head_d;
  logic                   up_q, up_d;
  logic [15:0]            max_track_q;

  // Request being added.
  logic [15:0] req_track_q, req_track_d;
  logic [7:0]  req_owner_q, req_owner_d;
  logic        req_rd_q, req_rd_d;

  // Walk accumulators.
  logic          slot_found_q, slot_found_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] match_cnt_q, match_cnt_d;
  logic          best_vld_q, best_vld_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [AW-1:0] best_age_q, best_age_d;
  logic [7:0]    best_owner_q, best_owner_d;
  logic          best_rd_q, best_rd_d;

  // Completion bookkeeping across the walks of one tick.
  logic          prev_vld_q, prev_vld_d;
  logic [AW-1:0] prev_idx_q, prev_idx_d;
  logic [AW-1:0] prev_age_q, prev_age_d;
  logic [KW-1:0] k_q, k_d;
  logic [KW-1:0] n_q, n_d;

  // Pending result word.
  result_t res_q, res_d;
  logic    load_ready;

  // Table memory ports.
  ent_t          mem [QUEUE_DEPTH];
  ent_t          rdata_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  ent_t          mem_wdata;

  logic item_fire;

  assign item_i.ready = (state_q == ST_IDLE);
  assign item_fire    = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_track_q <= 16'd255;
    end else if (cfg_i.valid) begin
      max_track_q <= cfg_i.max_track;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_ADD;
      ret_walk_q   <= 1'b0;
      cnt_q        <= '0;
      p_vld_q      <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      head_q       <= '0;
      up_q         <= 1'b1;
      slot_found_q <= 1'b0;
      match_cnt_q  <= '0;
      best_vld_q   <= 1'b0;
      prev_vld_q   <= 1'b0;
      k_q          <= '0;
      n_q          <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      ret_walk_q   <= ret_walk_d;
      cnt_q        <= cnt_d;
      p_vld_q      <= p_vld_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      head_q       <= head_d;
      up_q         <= up_d;
      slot_found_q <= slot_found_d;
      match_cnt_q  <= match_cnt_d;
      best_vld_q   <= best_vld_d;
      prev_vld_q   <= prev_vld_d;
      k_q          <= k_d;
      n_q          <= n_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p_idx_q      <= p_idx_d;
    req_track_q  <= req_track_d;
    req_owner_q  <= req_owner_d;
    req_rd_q     <= req_rd_d;
    slot_q       <= slot_d;
    best_idx_q   <= best_idx_d;
    best_age_q   <= best_age_d;
    best_owner_q <= best_owner_d;
    best_rd_q    <= best_rd_d;
    prev_idx_q   <= prev_idx_d;
    prev_age_q   <= prev_age_d;
    res_q        <= res_d;
  end

  // Sequencer: next state, memory accesses and result words.
  always_comb begin
    ent_t          ent;
    logic [AW-1:0] adj_age;
    logic [KW-1:0] n_calc;
    logic [KW-1:0] n_eff;
    logic          start_walk;
    logic          move_head;

    ent        = rdata_q;
    adj_age    = rdata_q.age;
    n_calc     = '0;
    n_eff      = n_q;
    start_walk = 1'b0;
    move_head  = 1'b0;

    state_d      = state_q;
    op_d         = op_q;
    ret_walk_d   = ret_walk_q;
    cnt_d        = cnt_q;
    p_vld_d      = 1'b0;
    p_idx_d      = p_idx_q;
    valid_d      = valid_q;
    count_d      = count_q;
    head_d       = head_q;
    up_d         = up_q;
    req_track_d  = req_track_q;
    req_owner_d  = req_owner_q;
    req_rd_d     = req_rd_q;
    slot_found_d = slot_found_q;
    slot_d       = slot_q;
    match_cnt_d  = match_cnt_q;
    best_vld_d   = best_vld_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    best_owner_d = best_owner_q;
    best_rd_d    = best_rd_q;
    prev_vld_d   = prev_vld_q;
    prev_idx_d   = prev_idx_q;
    prev_age_d   = prev_age_q;
    k_d          = k_q;
    n_d          = n_q;
    res_d        = res_q;

    rd_en     = 1'b0;
    rd_addr   = cnt_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = p_idx_q;
    mem_wdata = rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          if (item_i.mode == MODE_ADD) begin
            req_track_d = item_i.track;
            req_owner_d = item_i.requester_id;
            req_rd_d    = item_i.is_read;
            if ((count_q == CW'(QUEUE_DEPTH)) || (item_i.track > max_track_q)) begin
              res_d = '{kind: KIND_DROP, done_id: item_i.requester_id,
                        done_is_read: item_i.is_read, head_position: head_q,
                        last: 1'b1};
              ret_walk_d = 1'b0;
              state_d    = ST_EMIT;
            end else begin
              op_d       = OP_ADD;
              start_walk = 1'b1;
            end
          end else if (count_q != '0) begin
            op_d       = OP_SCAN;
            k_d        = '0;
            prev_vld_d = 1'b0;
            start_walk = 1'b1;
          end
        end
      end

      ST_WALK: begin
        // Issue one read per cycle.
        rd_en = (cnt_q < (AW + 1)'(QUEUE_DEPTH));
        if (rd_en) begin
          cnt_d = cnt_q + (AW + 1)'(1);
        end
        p_vld_d = rd_en;
        p_idx_d = cnt_q[AW-1:0];

        // Handle the entry whose data returned this cycle.
        if (p_vld_q) begin
          if (op_q == OP_ADD) begin
            if (valid_q[p_idx_q]) begin
              mem_we        = 1'b1;
              mem_wdata.age = ent.age + AW'(1);
            end else if (!slot_found_q) begin
              slot_found_d = 1'b1;
              slot_d       = p_idx_q;
            end
          end else if (valid_q[p_idx_q]) begin
            if (prev_vld_q && (p_idx_q == prev_idx_q)) begin
              // Retire the request delivered after the previous walk.
              valid_d[p_idx_q] = 1'b0;
              count_d          = count_q - CW'(1);
            end else begin
              // Close the rank gap left by the retired request.
              if (prev_vld_q && (ent.age > prev_age_q)) begin
                adj_age       = ent.age - AW'(1);
                mem_we        = 1'b1;
                mem_wdata.age = adj_age;
              end
              // Track the newest request at the head's track.
              if (ent.track == head_q) begin
                match_cnt_d = match_cnt_q + CW'(1);
                if (!best_vld_q || (adj_age < best_age_q)) begin
                  best_vld_d   = 1'b1;
                  best_idx_d   = p_idx_q;
                  best_age_d   = adj_age;
                  best_owner_d = ent.owner;
                  best_rd_d    = ent.rd;
                end
              end
            end
          end
          if (p_idx_q == AW'(QUEUE_DEPTH - 1)) begin
            state_d = ST_WEND;
          end
        end
      end

      ST_WEND: begin
        if (op_q == OP_ADD) begin
          // Store the new request as the newest entry.
          mem_we          = 1'b1;
          mem_waddr       = slot_q;
          mem_wdata.track = req_track_q;
          mem_wdata.owner = req_owner_q;
          mem_wdata.rd    = req_rd_q;
          mem_wdata.age   = '0;
          valid_d[slot_q] = 1'b1;
          count_d         = count_q + CW'(1);
          res_d = '{kind: KIND_ACCEPT, done_id: req_owner_q, done_is_read: req_rd_q,
                    head_position: head_q, last: 1'b1};
          ret_walk_d = 1'b0;
          state_d    = ST_EMIT;
        end else begin
          if (int'(match_cnt_q) > RESULT_LIMIT) begin
            n_calc = KW'(RESULT_LIMIT);
          end else begin
            n_calc = KW'(match_cnt_q);
          end
          if (k_q == '0) begin
            n_eff = n_calc;
            n_d   = n_calc;
          end
          if ((k_q == '0) && (n_calc == '0)) begin
            res_d = '{kind: KIND_EMPTY, done_id: 8'd0, done_is_read: 1'b0,
                      head_position: head_q, last: 1'b1};
            move_head  = 1'b1;
            ret_walk_d = 1'b0;
            state_d    = ST_EMIT;
          end else if (k_q < n_eff) begin
            res_d = '{kind: KIND_DONE, done_id: best_owner_q, done_is_read: best_rd_q,
                      head_position: head_q, last: ((k_q + KW'(1)) == n_eff)};
            prev_vld_d = 1'b1;
            prev_idx_d = best_idx_q;
            prev_age_d = best_age_q;
            k_d        = k_q + KW'(1);
            ret_walk_d = 1'b1;
            state_d    = ST_EMIT;
          end else begin
            // Last delivered request retired: the head moves on.
            move_head = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        if (load_ready) begin
          if (ret_walk_q) begin
            start_walk = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Fresh walk over the table.
    if (start_walk) begin
      cnt_d        = '0;
      match_cnt_d  = '0;
      best_vld_d   = 1'b0;
      slot_found_d = 1'b0;
      state_d      = ST_WALK;
    end

    // Head step or reversal at either end.
    if (move_head) begin
      if (up_q) begin
        if (head_q >= max_track_q) begin
          up_d = 1'b0;
        end else begin
          head_d = head_q + 16'd1;
        end
      end else begin
        if (head_q == 16'd0) begin
          up_d = 1'b1;
        end else begin
          head_d = head_q - 16'd1;
        end
      end
    end
  end

  // Output register toward the result channel.
  des_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (state_q == ST_EMIT),
    .load_ready_o (load_ready),
    .load_data_i  (res_q),
    .out_o        (result_o)
  );

`include "disk_elevator_scheduler_top_assert.svh"

  // The pending count always equals the number of occupied entries.
`DES_ASSERT_IMPL(a_count_matches_valid, 1'b1, count_q == CW'($countones(valid_q)))
  // A write-back never targets the entry being read in the same cycle.
`DES_ASSERT_IMPL(a_no_rw_collision, mem_we && rd_en, mem_waddr != rd_addr)
  // The head only moves at the end of a tick.
`DES_ASSERT_NEXT(a_head_holds_idle, (state_q == ST_IDLE) && !item_fire, $stable({head_q, up_q}))

endmodule

`default_nettype wire

// ===== tb/des_schedule_checker.sv =====
// Scoreboard for the disk elevator scheduler: predicts and checks every result word.
`timescale 1ns / 100ps

module des_schedule_checker
  import des_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  des_in_if         item_i,
  des_out_if        result_i,
  des_cfg_if        cfg_i,
  output int        errors_o,
  output int        pending_o
);

  // Local copy of the request table and the head state.
  bit          slot_used  [DEPTH];
  logic [15:0] slot_track [DEPTH];
  logic [7:0]  slot_owner [DEPTH];
  logic        slot_read  [DEPTH];
  int          slot_rank  [DEPTH];
  logic [15:0] head_track;
  bit          heading_up;
  logic [15:0] track_limit;

  result_t     awaited_results[$];
  int          mismatch_count;

  // Print one line for each mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("%0t des_schedule_checker: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Works out the result words that one accepted input word causes.
  task automatic schedule_item(input logic mode, input logic [15:0] trk,
                               input logic [7:0] who, input logic rd);
    int      free_slot;
    int      pick;
    int      gone_rank;
    int      served;
    bit      any_pending;
    result_t word;

    free_slot = -1;
    word = '0;
    if (mode == MODE_ADD) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      word.done_id       = who;
      word.done_is_read  = rd;
      word.head_position = head_track;
      word.last          = 1'b1;
      if (free_slot < 0 || trk > track_limit) begin
        word.kind = KIND_DROP;
      end else begin
        // The new request is the newest; everyone else gets one rank older.
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && slot_rank[i] < 255) slot_rank[i]++;
        end
        slot_used[free_slot]  = 1'b1;
        slot_track[free_slot] = trk;
        slot_owner[free_slot] = who;
        slot_read[free_slot]  = rd;
        slot_rank[free_slot]  = 0;
        word.kind = KIND_ACCEPT;
      end
      awaited_results.push_back(word);
      return;
    end

    // A tick on an empty table does nothing at all.
    any_pending = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i]) any_pending = 1'b1;
    end
    if (!any_pending) return;

    // Serve requests at the head track, newest first.
    served = 0;
    while (served < RESULT_LIMIT) begin
      pick = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && slot_track[i] == head_track &&
            (pick < 0 || slot_rank[i] < slot_rank[pick])) pick = i;
      end
      if (pick < 0) break;
      word.kind          = KIND_DONE;
      word.done_id       = slot_owner[pick];
      word.done_is_read  = slot_read[pick];
      word.head_position = head_track;
      word.last          = 1'b0;
      awaited_results.push_back(word);
      served++;
      gone_rank = slot_rank[pick];
      slot_used[pick] = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && slot_rank[i] > gone_rank) slot_rank[i]--;
      end
    end

    if (served == 0) begin
      word.kind          = KIND_EMPTY;
      word.done_id       = '0;
      word.done_is_read  = 1'b0;
      word.head_position = head_track;
      word.last          = 1'b1;
      awaited_results.push_back(word);
    end else begin
      word = awaited_results.pop_back();
      word.last = 1'b1;
      awaited_results.push_back(word);
    end

    // Step the head, or turn around at either end of the travel.
    if (heading_up) begin
      if (head_track >= track_limit) heading_up = 1'b0;
      else head_track++;
    end else begin
      if (head_track == 16'd0) heading_up = 1'b1;
      else head_track--;
    end
  endtask

  // Compares one delivered result word with the oldest expectation.
  task automatic check_result();
    result_t want;

    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected (kind %0d id %0d)",
                                result_i.kind, result_i.done_id));
      return;
    end
    want = awaited_results.pop_front();
    if (result_i.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", result_i.kind, want.kind));
    if (result_i.done_id !== want.done_id)
      report_mismatch($sformatf("done_id %0d, expected %0d", result_i.done_id,
                                want.done_id));
    if (result_i.done_is_read !== want.done_is_read)
      report_mismatch($sformatf("done_is_read %0d, expected %0d", result_i.done_is_read,
                                want.done_is_read));
    if (result_i.head_position !== want.head_position)
      report_mismatch($sformatf("head_position %0d, expected %0d",
                                result_i.head_position, want.head_position));
    if (result_i.last !== want.last)
      report_mismatch($sformatf("last %0d, expected %0d", result_i.last, want.last));
  endtask

  // Watch all three channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_used[i]  = 1'b0;
        slot_track[i] = '0;
        slot_owner[i] = '0;
        slot_read[i]  = 1'b0;
        slot_rank[i]  = 0;
      end
      head_track     = '0;
      heading_up     = 1'b1;
      track_limit    = 16'd255;
      mismatch_count = 0;
      awaited_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) check_result();
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) track_limit = cfg_i.max_track;
      if (item_i.valid === 1'b1 && item_i.ready === 1'b1) begin
        schedule_item(item_i.mode, item_i.track, item_i.requester_id, item_i.is_read);
      end
      errors_o  <= mismatch_count;
      pending_o <= awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_disk_elevator_scheduler_top.sv =====
// Testbench top for the disk elevator scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_disk_elevator_scheduler_top;
  import des_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  // Cycles the block may still be busy after the last expected word.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   error_count;
  int   words_pending;

  des_in_if  item_if ();
  des_out_if result_if ();
  des_cfg_if cfg_if ();

  disk_elevator_scheduler_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  des_schedule_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_i (result_if),
    .cfg_i    (cfg_if),
    .errors_o (error_count),
    .pending_o(words_pending)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_disk_elevator_scheduler_top: FAIL");
    $finish;
  end

  // The result receiver stalls in runs, with a stall rate that changes over time.
  initial begin
    int stall_pct;
    int stall_left;
    int window_left;

    stall_pct = 0;
    stall_left = 0;
    window_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (window_left == 0) begin
        window_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      window_left--;
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        result_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Presents one word and holds it until it is accepted; valid stays high after.
  task automatic send_word(input logic mode, input logic [15:0] trk,
                           input logic [7:0] who, input logic rd);
    @(negedge clk_i);
    item_if.valid        <= 1'b1;
    item_if.mode         <= mode;
    item_if.track        <= trk;
    item_if.requester_id <= who;
    item_if.is_read      <= rd;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
  endtask

  // Drops valid for the given number of cycles.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Holds the sender off until every expected word has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // Brings the block to rest and writes a new track limit.
  task automatic set_track_limit(input logic [15:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.max_track <= limit;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic in bursts; tracks mostly near the active range of the head.
  task automatic run_random(input int count, input logic [15:0] limit);
    int          burst;
    int          span;
    logic [15:0] trk;

    burst = 0;
    span = (limit > 16'd48) ? 48 : int'(limit) + 1;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst--;
      if ($urandom_range(0, 7) == 0) trk = 16'($urandom());
      else trk = 16'($urandom_range(0, span));
      send_word(($urandom_range(0, 9) < 4) ? MODE_TICK : MODE_ADD, trk, 8'($urandom()),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [15:0] limits [6];

    limits = '{16'd15, 16'd255, 16'd7, 16'd65535, 16'd1, 16'd40};
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.mode = MODE_ADD;
    item_if.track = '0;
    item_if.requester_id = '0;
    item_if.is_read = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_track = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Short sweep over three tracks: drops above the limit, newest first on a tie,
    // and a final tick on an empty table.
    set_track_limit(16'd2);
    send_word(MODE_ADD, 16'd0, 8'hff, 1'b1);
    send_word(MODE_ADD, 16'd2, 8'h00, 1'b0);
    send_word(MODE_ADD, 16'd3, 8'h33, 1'b1);
    send_word(MODE_ADD, 16'hffff, 8'h5a, 1'b0);
    send_word(MODE_ADD, 16'd1, 8'd1, 1'b1);
    send_word(MODE_ADD, 16'd1, 8'd2, 1'b0);
    repeat (4) send_word(MODE_TICK, 16'hffff, 8'hff, 1'b1);

    // Zero limit: fill the table at track 0, overflow it, then drain it in one tick.
    set_track_limit(16'd0);
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      send_word(MODE_ADD, 16'd0, 8'(k + 100), 1'(k));
    end
    send_word(MODE_ADD, 16'd0, 8'hee, 1'b1);
    send_word(MODE_ADD, 16'd1, 8'hdd, 1'b0);
    repeat (3) send_word(MODE_TICK, 16'd0, 8'd0, 1'b0);

    // Random phases; the limit moves up and down while requests stay stored.
    foreach (limits[p]) begin
      set_track_limit(limits[p]);
      run_random(75, limits[p]);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0 && words_pending == 0) begin
      $display("tb_disk_elevator_scheduler_top: PASS");
    end else begin
      $display("tb_disk_elevator_scheduler_top: FAIL");
    end
    $finish;
  end

endmodule
